### rtl/core/kpi_pkg.sv
package kpi_pkg;

  localparam int unsigned KEY_SLOTS = 64;
  localparam int unsigned ADDR_W    = $clog2(KEY_SLOTS);
  localparam int unsigned CNT_W     = $clog2(KEY_SLOTS + 1);
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned KEY_W     = TIME_W + 2 * POS_W;
  localparam int unsigned QUOT_W    = 15;
  localparam int unsigned DIVD_W    = TIME_W + QUOT_W;
  localparam int unsigned STEP_W    = $clog2(QUOT_W + 1);

  localparam logic [POS_W-1:0] SCENE_WIDTH_RST = 12'd1400;
  localparam logic [POS_W-1:0] SCENE_WIDTH_MIN = 12'd2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_JUMP   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NO_PAIR   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_JC_WAIT,
    S_DEL_RD,
    S_DEL_WR,
    S_Q_LD0,
    S_Q_CMP,
    S_Q_SETUP,
    S_Q_DIVY,
    S_Q_SETX,
    S_Q_MULX,
    S_Q_DIVX,
    S_Q_MOD
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [TIME_W-1:0] time_ms;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [5:0]        entry_index;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [6:0]       entry_count;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [TIME_W-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/core/kpi_ram.sv
module kpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/kpi_div.sv
module kpi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kpi_pkg::div_req_t req_i,
  output kpi_pkg::div_rsp_t rsp_o
);

  logic [kpi_pkg::TIME_W-1:0] rem_q;
  logic [kpi_pkg::QUOT_W-1:0] quo_q;
  logic [kpi_pkg::TIME_W-1:0] dvs_q;
  logic [kpi_pkg::STEP_W-1:0] step_q;
  logic                       busy_q;
  logic                       done_q;
  logic [kpi_pkg::TIME_W:0]   trial;
  logic                       ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem_q, quo_q[kpi_pkg::QUOT_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= kpi_pkg::STEP_W'(kpi_pkg::QUOT_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == kpi_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[kpi_pkg::DIVD_W-1:kpi_pkg::QUOT_W];
      quo_q <= req_i.dividend[kpi_pkg::QUOT_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? kpi_pkg::TIME_W'(trial - {1'b0, dvs_q}) : trial[kpi_pkg::TIME_W-1:0];
      quo_q <= {quo_q[kpi_pkg::QUOT_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/core/keyframe_path_interpolator.sv
// Keyframe table of up to 64 keys kept in time order in one single-port-read RAM, with one
// result beat per command, strobed by res_valid_o for one cycle; the receiver cannot stall it.
// start_i is taken while busy_o is low. Insert walks the table from the top down, moving each
// later key up with a read state and then a compare and write-back state; a jump cut adds a
// read and a second insert. Delete moves each following key down with a read and a write
// state. Query scans one key a cycle through the RAM read port, then uses one shared 15-step
// divider for y, for x and, on a wrapped x path, once more for the modulo.
module keyframe_path_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  kpi_pkg::item_t                in_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output kpi_pkg::result_t              res_o,
  input  logic                          cfg_we_i,
  input  logic [kpi_pkg::POS_W-1:0]     cfg_wdata_i
);

  kpi_pkg::state_e             state_q, state_d;
  kpi_pkg::item_t              item_q, item_d;
  logic [kpi_pkg::CNT_W-1:0]   count_q, count_d;
  logic [kpi_pkg::CNT_W-1:0]   pos_q, pos_d;
  kpi_pkg::key_t               ins_q, ins_d;
  logic                        second_q, second_d;
  kpi_pkg::key_t               prev_q, prev_d;
  kpi_pkg::key_t               cur_q, cur_d;
  logic [kpi_pkg::TIME_W-1:0]  num_q, num_d;
  logic [kpi_pkg::TIME_W-1:0]  den_q, den_d;
  logic                        neg_q, neg_d;
  logic [kpi_pkg::POS_W-1:0]   oy_q, oy_d;
  logic signed [13:0]          delta_q, delta_d;
  logic signed [14:0]          base_q, base_d;
  logic                        wrap_q, wrap_d;
  logic [kpi_pkg::POS_W-1:0]   sw_q;
  kpi_pkg::result_t            res_q, res_d;
  logic                        res_valid_q;
  logic                        fin;

  logic                        we;
  logic [kpi_pkg::ADDR_W-1:0]  waddr, raddr;
  kpi_pkg::key_t               wdata, rdata;
  logic [kpi_pkg::KEY_W-1:0]   rdata_raw;

  kpi_pkg::div_req_t           dreq;
  kpi_pkg::div_rsp_t           drsp;

  logic [kpi_pkg::POS_W-1:0]   w;
  logic signed [12:0]          dy;
  logic [kpi_pkg::POS_W-1:0]   ady;
  logic [13:0]                 adelta;
  logic signed [16:0]          qs;
  logic signed [17:0]          xv;
  logic [17:0]                 axv;
  logic [kpi_pkg::POS_W-1:0]   xl, xr, direct;
  logic signed [13:0]          around;
  logic                        x0_lt;
  logic [kpi_pkg::CNT_W:0]     need;

  kpi_ram #(
    .WIDTH(kpi_pkg::KEY_W),
    .DEPTH(kpi_pkg::KEY_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata = kpi_pkg::key_t'(rdata_raw);

  kpi_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  assign w      = (sw_q < kpi_pkg::SCENE_WIDTH_MIN) ? kpi_pkg::SCENE_WIDTH_MIN : sw_q;
  assign dy     = $signed({1'b0, cur_q.y}) - $signed({1'b0, prev_q.y});
  assign ady    = dy[12] ? kpi_pkg::POS_W'(-dy) : dy[kpi_pkg::POS_W-1:0];
  assign adelta = delta_q[13] ? 14'(-delta_q) : delta_q;
  // floored quotient from magnitude division
  assign qs     = neg_q ? -$signed({2'b0, drsp.quot} + 17'(drsp.rem != '0))
                        : $signed({2'b0, drsp.quot});
  assign xv     = 18'(base_q) + 18'(qs);
  assign axv    = xv[17] ? 18'(-xv) : xv;
  assign x0_lt  = prev_q.x < cur_q.x;
  assign xl     = x0_lt ? prev_q.x : cur_q.x;
  assign xr     = x0_lt ? cur_q.x : prev_q.x;
  assign direct = xr - xl;
  assign around = $signed({2'b0, w}) - $signed({2'b0, xr}) + $signed({2'b0, xl});
  assign need   = (count_q > kpi_pkg::CNT_W'(1)) ? (kpi_pkg::CNT_W+1)'(2)
                                                 : (kpi_pkg::CNT_W+1)'(1);

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    count_d  = count_q;
    pos_d    = pos_q;
    ins_d    = ins_q;
    second_d = second_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    num_d    = num_q;
    den_d    = den_q;
    neg_d    = neg_q;
    oy_d     = oy_q;
    delta_d  = delta_q;
    base_d   = base_q;
    wrap_d   = wrap_q;
    we       = 1'b0;
    waddr    = pos_q[kpi_pkg::ADDR_W-1:0];
    wdata    = ins_q;
    raddr    = kpi_pkg::ADDR_W'(pos_q - 1'b1);
    dreq     = '0;
    fin      = 1'b0;
    res_d    = '0;

    case (state_q)
      kpi_pkg::S_IDLE: begin
        if (start_i) begin
          item_d = in_i;
          case (in_i.cmd)
            kpi_pkg::CMD_INSERT: begin
              if (count_q >= kpi_pkg::CNT_W'(kpi_pkg::KEY_SLOTS)) begin
                fin          = 1'b1;
                res_d.status = kpi_pkg::ST_FULL;
              end else begin
                ins_d    = '{t: in_i.time_ms, x: in_i.pos_x, y: in_i.pos_y};
                second_d = 1'b0;
                pos_d    = count_q;
                state_d  = kpi_pkg::S_INS_RD;
              end
            end
            kpi_pkg::CMD_JUMP: begin
              if ({1'b0, count_q} + need > (kpi_pkg::CNT_W+1)'(kpi_pkg::KEY_SLOTS)) begin
                fin          = 1'b1;
                res_d.status = kpi_pkg::ST_FULL;
              end else if (count_q > kpi_pkg::CNT_W'(1)) begin
                raddr   = kpi_pkg::ADDR_W'(count_q - 1'b1);
                state_d = kpi_pkg::S_JC_WAIT;
              end else begin
                ins_d    = '{t: in_i.time_ms, x: in_i.pos_x, y: in_i.pos_y};
                second_d = 1'b0;
                pos_d    = count_q;
                state_d  = kpi_pkg::S_INS_RD;
              end
            end
            kpi_pkg::CMD_DELETE: begin
              if (32'(in_i.entry_index) >= 32'(count_q)) begin
                fin          = 1'b1;
                res_d.status = kpi_pkg::ST_BAD_INDEX;
              end else begin
                pos_d   = kpi_pkg::CNT_W'(in_i.entry_index);
                state_d = kpi_pkg::S_DEL_RD;
              end
            end
            default: begin
              if (count_q < kpi_pkg::CNT_W'(2)) begin
                fin          = 1'b1;
                res_d.status = kpi_pkg::ST_NO_PAIR;
              end else begin
                raddr   = '0;
                pos_d   = kpi_pkg::CNT_W'(1);
                state_d = kpi_pkg::S_Q_LD0;
              end
            end
          endcase
        end
      end

      kpi_pkg::S_INS_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          if (second_q) begin
            ins_d    = '{t: item_q.time_ms, x: item_q.pos_x, y: item_q.pos_y};
            second_d = 1'b0;
            pos_d    = count_q + 1'b1;
          end else begin
            fin     = 1'b1;
            state_d = kpi_pkg::S_IDLE;
          end
        end else begin
          state_d = kpi_pkg::S_INS_CMP;
        end
      end

      kpi_pkg::S_INS_CMP: begin
        we = 1'b1;
        if (rdata.t > ins_q.t) begin
          // later key moves up one slot
          wdata   = rdata;
          pos_d   = pos_q - 1'b1;
          state_d = kpi_pkg::S_INS_RD;
        end else begin
          count_d = count_q + 1'b1;
          if (second_q) begin
            ins_d    = '{t: item_q.time_ms, x: item_q.pos_x, y: item_q.pos_y};
            second_d = 1'b0;
            pos_d    = count_q + 1'b1;
            state_d  = kpi_pkg::S_INS_RD;
          end else begin
            fin     = 1'b1;
            state_d = kpi_pkg::S_IDLE;
          end
        end
      end

      kpi_pkg::S_JC_WAIT: begin
        ins_d.t  = (item_q.time_ms == '0) ? '0 : item_q.time_ms - 1'b1;
        ins_d.x  = rdata.x;
        ins_d.y  = rdata.y;
        second_d = 1'b1;
        pos_d    = count_q;
        state_d  = kpi_pkg::S_INS_RD;
      end

      kpi_pkg::S_DEL_RD: begin
        if (pos_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          fin     = 1'b1;
          state_d = kpi_pkg::S_IDLE;
        end else begin
          raddr   = kpi_pkg::ADDR_W'(pos_q + 1'b1);
          state_d = kpi_pkg::S_DEL_WR;
        end
      end

      kpi_pkg::S_DEL_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        pos_d   = pos_q + 1'b1;
        state_d = kpi_pkg::S_DEL_RD;
      end

      kpi_pkg::S_Q_LD0: begin
        prev_d  = rdata;
        raddr   = pos_q[kpi_pkg::ADDR_W-1:0];
        state_d = kpi_pkg::S_Q_CMP;
      end

      kpi_pkg::S_Q_CMP: begin
        if (prev_q.t <= item_q.time_ms && rdata.t >= item_q.time_ms) begin
          cur_d   = rdata;
          den_d   = rdata.t - prev_q.t;
          num_d   = item_q.time_ms - prev_q.t;
          state_d = kpi_pkg::S_Q_SETUP;
        end else begin
          prev_d = rdata;
          pos_d  = pos_q + 1'b1;
          if (pos_q + 1'b1 >= count_q) begin
            fin          = 1'b1;
            res_d.status = kpi_pkg::ST_NO_PAIR;
            state_d      = kpi_pkg::S_IDLE;
          end else begin
            raddr = kpi_pkg::ADDR_W'(pos_q + 1'b1);
          end
        end
      end

      kpi_pkg::S_Q_SETUP: begin
        if (den_q == '0) begin
          fin         = 1'b1;
          res_d.out_x = prev_q.x;
          res_d.out_y = prev_q.y;
          state_d     = kpi_pkg::S_IDLE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = kpi_pkg::DIVD_W'(ady * num_q);
          dreq.divisor  = den_q;
          neg_d         = dy[12];
          state_d       = kpi_pkg::S_Q_DIVY;
        end
      end

      kpi_pkg::S_Q_DIVY: begin
        if (drsp.done) begin
          oy_d    = kpi_pkg::POS_W'(18'($signed({1'b0, prev_q.y})) + 18'(qs));
          state_d = kpi_pkg::S_Q_SETX;
        end
      end

      kpi_pkg::S_Q_SETX: begin
        wrap_d = around < $signed({2'b0, direct});
        if (around < $signed({2'b0, direct})) begin
          delta_d = x0_lt ? -around : around;
          base_d  = $signed({3'b0, prev_q.x}) + (x0_lt ? $signed({3'b0, w}) : 15'sd0);
        end else begin
          delta_d = $signed({2'b0, cur_q.x}) - $signed({2'b0, prev_q.x});
          base_d  = $signed({3'b0, prev_q.x});
        end
        state_d = kpi_pkg::S_Q_MULX;
      end

      kpi_pkg::S_Q_MULX: begin
        dreq.start    = 1'b1;
        dreq.dividend = kpi_pkg::DIVD_W'(adelta * num_q);
        dreq.divisor  = den_q;
        neg_d         = delta_q[13];
        state_d       = kpi_pkg::S_Q_DIVX;
      end

      kpi_pkg::S_Q_DIVX: begin
        if (drsp.done) begin
          if (wrap_q) begin
            // euclidean reduction into 0..w-1
            dreq.start    = 1'b1;
            dreq.dividend = kpi_pkg::DIVD_W'(axv);
            dreq.divisor  = kpi_pkg::TIME_W'(w);
            neg_d         = xv[17];
            state_d       = kpi_pkg::S_Q_MOD;
          end else begin
            fin         = 1'b1;
            res_d.out_x = xv[kpi_pkg::POS_W-1:0];
            res_d.out_y = oy_q;
            state_d     = kpi_pkg::S_IDLE;
          end
        end
      end

      kpi_pkg::S_Q_MOD: begin
        if (drsp.done) begin
          fin = 1'b1;
          if (neg_q && drsp.rem != '0) begin
            res_d.out_x = w - drsp.rem[kpi_pkg::POS_W-1:0];
          end else begin
            res_d.out_x = drsp.rem[kpi_pkg::POS_W-1:0];
          end
          res_d.out_y = oy_q;
          state_d     = kpi_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kpi_pkg::S_IDLE;
      end
    endcase

    res_d.entry_count = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpi_pkg::S_IDLE;
      count_q     <= '0;
      second_q    <= 1'b0;
      res_valid_q <= 1'b0;
      sw_q        <= kpi_pkg::SCENE_WIDTH_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      second_q    <= second_d;
      res_valid_q <= fin;
      if (cfg_we_i) begin
        sw_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pos_q   <= pos_d;
    ins_q   <= ins_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    num_q   <= num_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    oy_q    <= oy_d;
    delta_q <= delta_d;
    base_q  <= base_d;
    wrap_q  <= wrap_d;
    if (fin) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = state_q != kpi_pkg::S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### tb/keyframe_path_interpolator_tb.sv
module keyframe_path_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kpi_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  item_t in_i = '0;
  logic busy_o;
  logic res_valid_o;
  result_t res_o;
  logic cfg_we_i = 1'b0;
  logic [POS_W-1:0] cfg_wdata_i = '0;

  keyframe_path_interpolator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // local copy of the keyframe table
  logic [TIME_W-1:0] tbl_time [KEY_SLOTS];
  logic [POS_W-1:0]  tbl_x    [KEY_SLOTS];
  logic [POS_W-1:0]  tbl_y    [KEY_SLOTS];
  int unsigned       tbl_count;
  logic [POS_W-1:0]  wrap_width;

  result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit idle_enable;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && (a < 0)) q = q - 1;
    return q;
  endfunction

  function automatic void table_insert(logic [TIME_W-1:0] t, logic [POS_W-1:0] x,
                                       logic [POS_W-1:0] y);
    int unsigned p;
    p = tbl_count;
    while (p > 0 && tbl_time[p-1] > t) begin
      tbl_time[p] = tbl_time[p-1];
      tbl_x[p] = tbl_x[p-1];
      tbl_y[p] = tbl_y[p-1];
      p--;
    end
    tbl_time[p] = t;
    tbl_x[p] = x;
    tbl_y[p] = y;
    tbl_count++;
  endfunction

  function automatic result_t apply_command(item_t it);
    result_t r;
    int unsigned i;
    int unsigned need;
    longint w, x0, x1, y0, y1, den, num, l, rr, direct, around, xv;
    logic [POS_W-1:0] lx, ly;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_INSERT: begin
        if (tbl_count >= KEY_SLOTS) r.status = ST_FULL;
        else table_insert(it.time_ms, it.pos_x, it.pos_y);
      end
      CMD_JUMP: begin
        need = (tbl_count > 1) ? 2 : 1;
        if (tbl_count + need > KEY_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_count > 1) begin
            lx = tbl_x[tbl_count-1];
            ly = tbl_y[tbl_count-1];
            table_insert((it.time_ms == 0) ? '0 : it.time_ms - 1'b1, lx, ly);
          end
          table_insert(it.time_ms, it.pos_x, it.pos_y);
        end
      end
      CMD_DELETE: begin
        if (it.entry_index >= tbl_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = it.entry_index; i + 1 < tbl_count; i++) begin
            tbl_time[i] = tbl_time[i+1];
            tbl_x[i] = tbl_x[i+1];
            tbl_y[i] = tbl_y[i+1];
          end
          tbl_count--;
        end
      end
      default: begin
        w = (wrap_width < 2) ? 2 : wrap_width;
        for (i = 1; i < tbl_count; i++)
          if (tbl_time[i-1] <= it.time_ms && tbl_time[i] >= it.time_ms) break;
        if (tbl_count < 2 || i >= tbl_count) begin
          r.status = ST_NO_PAIR;
        end else begin
          x0 = tbl_x[i-1]; x1 = tbl_x[i];
          y0 = tbl_y[i-1]; y1 = tbl_y[i];
          den = longint'(tbl_time[i]) - longint'(tbl_time[i-1]);
          num = longint'(it.time_ms) - longint'(tbl_time[i-1]);
          if (den == 0) begin
            r.out_x = x0[POS_W-1:0];
            r.out_y = y0[POS_W-1:0];
          end else begin
            xv = y0 + floor_quot((y1 - y0) * num, den);
            r.out_y = xv[POS_W-1:0];
            l = (x0 < x1) ? x0 : x1;
            rr = (x0 < x1) ? x1 : x0;
            direct = rr - l;
            around = w - rr + l;
            if (around < direct) begin
              if (l == x0) xv = floor_quot((x0 + w) * den - around * num, den);
              else xv = floor_quot(x0 * den + around * num, den);
              xv = xv % w;
              if (xv < 0) xv = xv + w;
            end else begin
              xv = x0 + floor_quot((x1 - x0) * num, den);
            end
            r.out_x = xv[POS_W-1:0];
          end
        end
      end
    endcase
    r.entry_count = tbl_count[6:0];
    return r;
  endfunction

  // one command beat; start stays high so back-to-back beats need no gap
  task automatic send_item(cmd_e c, int unsigned t, int unsigned x, int unsigned y,
                           int unsigned idx);
    item_t it;
    int unsigned gap;
    it.cmd = c;
    it.time_ms = TIME_W'(t);
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.entry_index = 6'(idx);
    if (idle_enable && $urandom_range(99) < 36) begin
      @(negedge clk_i);
      start_i = 1'b0;
      in_i = item_t'($bits(item_t)'({$urandom, $urandom}));
      gap = $urandom_range(1, 6);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    in_i = it;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    pending_results = {pending_results, apply_command(it)};
  endtask

  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_width(logic [POS_W-1:0] w);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = POS_W'($urandom);
    wrap_width = w;
  endtask

  task automatic clear_table;
    while (tbl_count > 0)
      send_item(CMD_DELETE, $urandom, $urandom, $urandom, $urandom_range(tbl_count - 1));
  endtask

  task automatic test_empty_and_single;
    send_item(CMD_QUERY, 0, 0, 0, 0);
    send_item(CMD_DELETE, 0, 0, 0, 0);
    send_item(CMD_JUMP, 0, 4095, 4095, 63);
    send_item(CMD_QUERY, 0, 0, 0, 0);
    send_item(CMD_JUMP, 32'h7fff_ffff, 0, 0, 0);
    send_item(CMD_QUERY, 32'h7fff_ffff, 0, 0, 0);
    send_item(CMD_QUERY, 32'h4000_0000, 0, 0, 0);
    send_item(CMD_DELETE, 0, 0, 0, 63);
    clear_table();
  endtask

  task automatic test_pairs_and_wrap;
    // equal times keep arrival order, zero span returns the first key
    send_item(CMD_INSERT, 100, 10, 20, 0);
    send_item(CMD_INSERT, 100, 30, 40, 0);
    send_item(CMD_QUERY, 100, 0, 0, 0);
    send_item(CMD_INSERT, 1100, 1390, 0, 0);
    send_item(CMD_QUERY, 600, 0, 0, 0);
    send_item(CMD_QUERY, 1100, 0, 0, 0);
    send_item(CMD_QUERY, 1101, 0, 0, 0);
    send_item(CMD_INSERT, 1107, 5, 4095, 0);
    send_item(CMD_QUERY, 1103, 0, 0, 0);
    send_item(CMD_INSERT, 2000, 4095, 0, 0);
    send_item(CMD_QUERY, 1500, 0, 0, 0);
    send_item(CMD_JUMP, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0);
    send_item(CMD_DELETE, 0, 0, 0, 7);
    send_item(CMD_DELETE, 0, 0, 0, 2);
    clear_table();
  endtask

  task automatic test_full_table;
    while (tbl_count < KEY_SLOTS)
      send_item(CMD_INSERT, $urandom_range(5000), $urandom, $urandom, $urandom);
    send_item(CMD_INSERT, 7, 1, 1, 0);
    send_item(CMD_JUMP, 9, 1, 1, 0);
    send_item(CMD_QUERY, 2500, 0, 0, 0);
    send_item(CMD_DELETE, 0, 0, 0, 63);
    send_item(CMD_JUMP, 9, 1, 1, 0);
    send_item(CMD_DELETE, 0, 0, 0, 0);
    send_item(CMD_JUMP, 9, 1, 1, 0);
    send_item(CMD_QUERY, 8, 0, 0, 0);
    clear_table();
  endtask

  task automatic test_width_extremes;
    logic [POS_W-1:0] widths [4];
    widths = '{12'd0, 12'd1, 12'd2, 12'd4095};
    foreach (widths[k]) begin
      write_width(widths[k]);
      send_item(CMD_INSERT, 0, 0, 7, 0);
      send_item(CMD_INSERT, 9, 4095, 3, 0);
      send_item(CMD_INSERT, 20, 1, 3000, 0);
      send_item(CMD_QUERY, 4, 0, 0, 0);
      send_item(CMD_QUERY, 13, 0, 0, 0);
      clear_table();
    end
  endtask

  function automatic int unsigned pick_time();
    int unsigned j;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 0;
      2: return {TIME_W{1'b1}} - $urandom_range(3);
      default: begin
        if (tbl_count == 0) return $urandom_range(4000);
        j = $urandom_range(tbl_count - 1);
        return tbl_time[j] + $urandom_range(600) - 200;
      end
    endcase
  endfunction

  function automatic int unsigned pick_pos();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return (wrap_width < 2 ? 2 : wrap_width) - $urandom_range(1, 20);
      2: return {POS_W{1'b1}} - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int unsigned n);
    int unsigned k, roll;
    for (k = 0; k < n; k++) begin
      idle_enable = !(k >= n / 3 && k < n / 2);
      roll = $urandom_range(99);
      if (roll < (tbl_count < 4 ? 60 : tbl_count > 58 ? 15 : 30))
        send_item(CMD_INSERT, pick_time(), pick_pos(), pick_pos(), $urandom);
      else if (roll < 40)
        send_item(CMD_JUMP, pick_time(), pick_pos(), pick_pos(), $urandom);
      else if (roll < (tbl_count > 50 ? 70 : 52))
        send_item(CMD_DELETE, $urandom, $urandom, $urandom,
                  $urandom_range(9) == 0 ? $urandom : $urandom_range(tbl_count));
      else
        send_item(CMD_QUERY, pick_time(), $urandom, $urandom, $urandom);
    end
    idle_enable = 1'b1;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (res_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual %p", $time, res_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, res_o.status);
          mismatches++;
        end
        if (res_o.out_x !== want.out_x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.out_x, res_o.out_x);
          mismatches++;
        end
        if (res_o.out_y !== want.out_y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.out_y, res_o.out_y);
          mismatches++;
        end
        if (res_o.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   res_o.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL keyframe_path_interpolator");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tbl_count = 0;
    wrap_width = SCENE_WIDTH_RST;
    idle_enable = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_single();
    test_pairs_and_wrap();
    test_full_table();
    test_width_extremes();
    write_width(SCENE_WIDTH_RST);
    test_random(350);
    write_width(12'd2);
    test_random(150);
    write_width(12'd4095);
    test_random(200);
    write_width(POS_W'($urandom_range(2, 4095)));
    test_random(200);
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS keyframe_path_interpolator");
    end else begin
      $display("FAIL keyframe_path_interpolator");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/kpi_pkg.sv
rtl/core/kpi_ram.sv
rtl/core/kpi_div.sv
rtl/core/keyframe_path_interpolator.sv
tb/keyframe_path_interpolator_tb.sv
